### hw/rtl/tone_pattern_sequencer_unit_macros.svh
// Assertion helpers shared by the tone pattern sequencer RTL.
`ifndef TONE_PATTERN_SEQUENCER_UNIT_MACROS_SVH
`define TONE_PATTERN_SEQUENCER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define TPS_ASSERT_IMPLY(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("tone sequencer implication failed");

// Expression must never be true.
`define TPS_ASSERT_NEVER(lbl, clk_sig, rstn_sig, expr) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) !(expr)) \
        else $error("tone sequencer forbidden condition seen");

`else

`define TPS_ASSERT_IMPLY(lbl, clk_sig, rstn_sig, ante, cons)
`define TPS_ASSERT_NEVER(lbl, clk_sig, rstn_sig, expr)

`endif

`endif

### hw/rtl/tps_pkg.sv
package tps_pkg;

    localparam int unsigned DEFAULT_TABLE_DEPTH = 64;

    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned IN_TUSER_W  = 3;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned OUT_TUSER_W = 2;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned ENTRY_W     = 32;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Action codes on the result stream
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_TONE    = 2'd1;
    localparam logic [1:0] ACT_SILENCE = 2'd2;

    // Player state codes on the result stream
    localparam logic [1:0] PS_STOPPED = 2'd0;
    localparam logic [1:0] PS_PLAYING = 2'd1;
    localparam logic [1:0] PS_PAUSED  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_COUNT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DURATION   = 2'd2;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_START  = 3'd1,
        CMD_RESUME = 3'd2,
        CMD_PAUSE  = 3'd3,
        CMD_STOP   = 3'd4,
        CMD_WRITE  = 3'd5,
        CMD_NONE   = 3'd6
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        wr_ok;
        logic [15:0] elapsed_ms;
        logic [5:0]  entry_index;
        logic [15:0] entry_freq;
        logic [15:0] entry_duration;
    } item_t;

    function automatic int unsigned addr_w(input int unsigned depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

### hw/rtl/tps_ram.sv
module tps_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [tps_pkg::addr_w(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic                                re,
    input  logic [tps_pkg::addr_w(DEPTH)-1:0]   raddr_a,
    input  logic [tps_pkg::addr_w(DEPTH)-1:0]   raddr_b,
    output logic [WIDTH-1:0]                    rdata_a,
    output logic [WIDTH-1:0]                    rdata_b
);
    import tps_pkg::*;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

### hw/rtl/tps_front.sv
module tps_front #(
    parameter int unsigned TABLE_DEPTH = tps_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tps_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [tps_pkg::IN_TUSER_W-1:0]  s_tuser,
    input  logic                            q_full,
    output logic                            q_push,
    output tps_pkg::item_t                  q_item
);
    import tps_pkg::*;

    cmd_t cmd;

    always_comb
    begin
        unique case (s_tuser)
            3'd0:    cmd = CMD_TICK;
            3'd1:    cmd = CMD_START;
            3'd2:    cmd = CMD_RESUME;
            3'd3:    cmd = CMD_PAUSE;
            3'd4:    cmd = CMD_STOP;
            3'd5:    cmd = CMD_WRITE;
            default: cmd = CMD_NONE;
        endcase
    end

    assign q_item.cmd            = cmd;
    assign q_item.elapsed_ms     = s_tdata[15:0];
    assign q_item.entry_index    = s_tdata[21:16];
    assign q_item.entry_freq     = s_tdata[37:22];
    assign q_item.entry_duration = s_tdata[53:38];
    // drop writes that fall outside the table
    assign q_item.wr_ok          = 32'(s_tdata[21:16]) < 32'(TABLE_DEPTH);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

### hw/rtl/tps_fifo.sv
module tps_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tps_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output tps_pkg::item_t  pop_item,
    output logic            empty
);
    import tps_pkg::*;

    localparam logic [QUEUE_PTR_W-1:0] LAST_PTR = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_CNT_W-1:0] FULL_CNT = QUEUE_CNT_W'(QUEUE_DEPTH);

    item_t                  mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full     = count_reg == FULL_CNT;
    assign empty    = count_reg == '0;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hw/rtl/tps_back.sv
module tps_back #(
    parameter int unsigned TABLE_DEPTH = tps_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [tps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tps_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             q_empty,
    input  tps_pkg::item_t                   q_item,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tps_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic [tps_pkg::OUT_TUSER_W-1:0]  m_tuser
);
    import tps_pkg::*;

    localparam int unsigned AW        = addr_w(TABLE_DEPTH);
    localparam int unsigned DEPTH_CAP = (TABLE_DEPTH > 127) ? 127 : TABLE_DEPTH;
    localparam logic [6:0]  CAP_LEN   = 7'(DEPTH_CAP);

    typedef enum logic [1:0] {
        BK_FETCH = 2'b01,
        BK_EXEC  = 2'b10
    } bk_state_t;

    typedef enum logic [2:0] {
        RUN_STOPPED = 3'b001,
        RUN_PLAYING = 3'b010,
        RUN_PAUSED  = 3'b100
    } run_t;

    typedef struct packed {
        run_t        run;
        logic        ready;
        logic        pend;
        logic [6:0]  idx;
        logic [31:0] ne;
        logic [15:0] pd;
        logic [31:0] te;
    } play_t;

    bk_state_t state_reg, state_next;
    play_t     play_reg, play_next;
    item_t     cur_reg;

    logic [6:0]  plen_reg;
    logic [15:0] rc_reg;
    logic [15:0] maxd_reg;

    logic        out_valid_reg;
    logic [1:0]  out_act_reg;
    logic [15:0] out_freq_reg;
    logic [15:0] out_dur_reg;
    logic [1:0]  out_ps_reg;

    logic [6:0]    eff_len;
    logic          at_end;
    logic [6:0]    next_idx;
    logic [31:0]   idx_ext, next_ext, widx_ext;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [ENTRY_W-1:0] ram_wdata, rdata_a, rdata_b;
    logic          exec_fire;

    logic [1:0]  act;
    logic [15:0] tone_f, tone_d;
    logic [1:0]  ps_code;

    assign eff_len  = (plen_reg > CAP_LEN) ? CAP_LEN : plen_reg;
    assign at_end   = play_reg.idx >= eff_len;
    // second port fetches the note the tick may move on to
    assign next_idx = at_end ? 7'd0 : play_reg.idx + 7'd1;

    assign idx_ext     = 32'(play_reg.idx);
    assign next_ext    = 32'(next_idx);
    assign widx_ext    = 32'(q_item.entry_index);
    assign ram_raddr_a = idx_ext[AW-1:0];
    assign ram_raddr_b = next_ext[AW-1:0];
    assign ram_waddr   = widx_ext[AW-1:0];
    assign ram_wdata   = {q_item.entry_duration, q_item.entry_freq};

    assign q_pop     = (state_reg == BK_FETCH) && !q_empty;
    assign ram_we    = q_pop && (q_item.cmd == CMD_WRITE) && q_item.wr_ok;
    assign exec_fire = (state_reg == BK_EXEC) && (!out_valid_reg || m_tready);

    tps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (q_pop),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_comb
    begin
        unique case (state_reg)
            BK_FETCH: state_next = q_empty ? BK_FETCH : BK_EXEC;
            BK_EXEC:  state_next = exec_fire ? BK_FETCH : BK_EXEC;
            default:  state_next = BK_FETCH;
        endcase
    end

    always_comb
    begin
        logic        limit_hit;
        logic [15:0] pd_inc;
        logic        in_range;
        logic [15:0] dur_use;
        logic [15:0] freq_a, dur_a, dur_b;
        logic [32:0] ne_sum, te_sum;

        freq_a    = rdata_a[15:0];
        dur_a     = rdata_a[31:16];
        dur_b     = rdata_b[31:16];
        limit_hit = (maxd_reg != 16'd0) && (play_reg.te >= {16'd0, maxd_reg});
        pd_inc    = 16'd0;
        in_range  = 1'b0;
        dur_use   = dur_a;
        ne_sum    = '0;
        te_sum    = '0;
        play_next = play_reg;
        act       = ACT_NONE;
        tone_f    = 16'd0;
        tone_d    = 16'd0;

        unique case (cur_reg.cmd)
            CMD_TICK:
            begin
                if (play_reg.run == RUN_PLAYING)
                begin
                    if (at_end || limit_hit)
                    begin
                        if (limit_hit)
                        begin
                            play_next.run = RUN_STOPPED;
                            play_next.ne  = '0;
                            play_next.pd  = '0;
                            play_next.te  = '0;
                            act           = ACT_SILENCE;
                        end
                        play_next.idx = '0;
                        if (rc_reg != 16'd0)
                        begin
                            pd_inc       = play_next.pd + 16'd1;
                            play_next.pd = pd_inc;
                            if (pd_inc >= rc_reg)
                            begin
                                play_next.run = RUN_STOPPED;
                                play_next.ne  = '0;
                                play_next.pd  = '0;
                                play_next.te  = '0;
                                act           = ACT_SILENCE;
                            end
                        end
                        else
                        begin
                            play_next.run = RUN_STOPPED;
                            play_next.ne  = '0;
                            play_next.pd  = '0;
                            play_next.te  = '0;
                            act           = ACT_SILENCE;
                        end
                        in_range = eff_len != 7'd0;
                        dur_use  = dur_b;
                    end
                    else if (play_reg.pend && freq_a != 16'd0)
                    begin
                        act            = ACT_TONE;
                        tone_f         = freq_a;
                        tone_d         = dur_a;
                        play_next.pend = 1'b0;
                        in_range       = 1'b1;
                    end
                    else
                    begin
                        in_range = 1'b1;
                        if (dur_a != 16'd0 && play_reg.ne >= {16'd0, dur_a})
                        begin
                            play_next.ne   = play_reg.ne - {16'd0, dur_a};
                            play_next.idx  = play_reg.idx + 7'd1;
                            play_next.pend = 1'b1;
                            in_range       = (play_reg.idx + 7'd1) < eff_len;
                            dur_use        = dur_b;
                        end
                    end
                    // advance the timers, saturating
                    if (play_next.run == RUN_PLAYING)
                    begin
                        if (in_range && dur_use != 16'd0)
                        begin
                            ne_sum       = {1'b0, play_next.ne} + 33'(cur_reg.elapsed_ms);
                            play_next.ne = ne_sum[32] ? '1 : ne_sum[31:0];
                        end
                        if (maxd_reg != 16'd0)
                        begin
                            te_sum       = {1'b0, play_next.te} + 33'(cur_reg.elapsed_ms);
                            play_next.te = te_sum[32] ? '1 : te_sum[31:0];
                        end
                    end
                end
            end
            CMD_START:
            begin
                play_next.ready = 1'b0;
                play_next.ne    = '0;
                play_next.pd    = '0;
                play_next.idx   = '0;
                play_next.te    = '0;
                if (plen_reg == 7'd0)
                begin
                    play_next.run = RUN_STOPPED;
                end
                else
                begin
                    play_next.run   = RUN_PLAYING;
                    play_next.ready = 1'b1;
                    play_next.pend  = 1'b1;
                end
            end
            CMD_RESUME:
            begin
                if (play_reg.ready)
                begin
                    play_next.run = RUN_PLAYING;
                end
            end
            CMD_PAUSE:
            begin
                play_next.run = RUN_PAUSED;
                act           = ACT_SILENCE;
            end
            CMD_STOP:
            begin
                play_next.run = RUN_STOPPED;
                play_next.idx = '0;
                play_next.ne  = '0;
                play_next.pd  = '0;
                play_next.te  = '0;
                act           = ACT_SILENCE;
            end
            default:
            begin
                act = ACT_NONE;
            end
        endcase
    end

    always_comb
    begin
        unique case (play_next.run)
            RUN_PLAYING: ps_code = PS_PLAYING;
            RUN_PAUSED:  ps_code = PS_PAUSED;
            default:     ps_code = PS_STOPPED;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= '0;
            rc_reg   <= '0;
            maxd_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LENGTH: plen_reg <= cfg_data[6:0];
                CFG_REPEAT_COUNT:   rc_reg   <= cfg_data;
                CFG_MAX_DURATION:   maxd_reg <= cfg_data;
                default:            plen_reg <= plen_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_FETCH;
            play_reg      <= '{run: RUN_STOPPED, ready: 1'b0, pend: 1'b0, idx: '0,
                               ne: '0, pd: '0, te: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire)
            begin
                play_reg      <= play_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_item;
        end
        if (exec_fire)
        begin
            out_act_reg  <= act;
            out_freq_reg <= tone_f;
            out_dur_reg  <= tone_d;
            out_ps_reg   <= ps_code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_act_reg;
    assign m_tdata  = {6'd0, out_ps_reg, out_dur_reg, out_freq_reg};

endmodule

### hw/rtl/tone_pattern_sequencer_unit.sv
// Tone pattern sequencer: plays a table of TABLE_DEPTH notes (frequency and duration), driven
// by tick and command items on the input stream, one result per item on the output stream.
// The input side takes one item per clock into a two-entry command queue while it is not full;
// the execution side pops an item in BK_FETCH, which starts the registered note-table read,
// then updates the player and loads the output register in BK_EXEC, and pops no new item
// until that one leaves BK_EXEC. An item's result goes from the queue through the table read
// and the player update into the output register. Results
// wait in an output register, so a stalled output does not stop the input until the queue
// fills. Write configuration only while no item is in flight. Table entries read before
// ever being written give undefined tone fields.
`include "tone_pattern_sequencer_unit_macros.svh"

module tone_pattern_sequencer_unit #(
    parameter int unsigned TABLE_DEPTH = tps_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [15:0] elapsed_ms, [21:16] entry_index, [37:22] entry_freq, [53:38] entry_duration
    input  logic [tps_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [2:0] mode
    input  logic [tps_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [15:0] tone_freq, [31:16] tone_duration, [33:32] player_state
    output logic [tps_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [1:0] action
    output logic [tps_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tps_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tps_pkg::*;

    logic  q_push, q_pop, q_full, q_empty;
    item_t push_item, pop_item;

    assign cfg_ready = 1'b1;

    tps_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    tps_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    tps_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_item    (pop_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .m_tuser   (m_axis_tuser)
    );

    `TPS_ASSERT_NEVER(a_pop_empty, clk, rst_n, q_pop && q_empty)
    `TPS_ASSERT_IMPLY(a_tone_playing, clk, rst_n, m_axis_tvalid && m_axis_tuser == ACT_TONE,
                      m_axis_tdata[33:32] == PS_PLAYING && m_axis_tdata[15:0] != 16'd0)
    `TPS_ASSERT_IMPLY(a_silence_idle, clk, rst_n, m_axis_tvalid && m_axis_tuser == ACT_SILENCE,
                      m_axis_tdata[33:32] != PS_PLAYING)

endmodule

### tb/tone_pattern_sequencer_checker.sv
module tone_pattern_sequencer_checker #(
    parameter int unsigned TABLE_DEPTH = tps_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    // [15:0] elapsed_ms, [21:16] entry_index, [37:22] entry_freq, [53:38] entry_duration
    input  logic [tps_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [2:0] mode
    input  logic [tps_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [15:0] tone_freq, [31:16] tone_duration, [33:32] player_state
    input  logic [tps_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [1:0] action
    input  logic [tps_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [tps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tps_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int unsigned                      fail_count,
    output int unsigned                      results_due,
    output int unsigned                      tones_seen,
    output int unsigned                      silences_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import tps_pkg::*;

    localparam int unsigned AW = addr_w(TABLE_DEPTH);

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] freq;
        logic [15:0] dur;
        logic [1:0]  state;
    } player_result_t;

    // Register copies
    logic [6:0]  len_cfg;
    logic [15:0] repeat_cfg;
    logic [15:0] limit_cfg;

    // Player state
    logic [1:0]  run_state_q;
    bit          armed;
    bit          note_due;
    logic [6:0]  note_pos;
    logic [31:0] note_ms;
    logic [31:0] total_ms;
    logic [15:0] passes;
    logic [15:0] freq_mem [TABLE_DEPTH];
    logic [15:0] dur_mem [TABLE_DEPTH];

    player_result_t due_results [$];

    function automatic logic [AW-1:0] slot(input logic [31:0] pos);
        return pos[AW-1:0];
    endfunction

    function automatic int unsigned active_length();
        return (32'(len_cfg) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(len_cfg);
    endfunction

    function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {17'd0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic void halt_player();
        run_state_q = PS_STOPPED;
        note_pos    = '0;
        note_ms     = '0;
        passes      = '0;
        total_ms    = '0;
    endfunction

    function automatic void reset_player();
        len_cfg     = '0;
        repeat_cfg  = '0;
        limit_cfg   = '0;
        armed       = 1'b0;
        note_due    = 1'b0;
        halt_player();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            freq_mem[slot(32'(i))] = '0;
            dur_mem[slot(32'(i))]  = '0;
        end
        due_results.delete();
    endfunction

    // One tick: stop at the time limit, wrap or stop at the end, announce a due tone, or move on.
    function automatic logic [1:0] advance_note(output logic [15:0] f, output logic [15:0] d);
        logic [1:0] act;
        logic       limit_hit;
        act = ACT_NONE;
        f   = '0;
        d   = '0;
        limit_hit = (limit_cfg != 16'd0) && (total_ms >= {16'd0, limit_cfg});
        if (32'(note_pos) >= active_length() || limit_hit) begin
            if (limit_hit) begin
                halt_player();
                act = ACT_SILENCE;
            end
            note_pos = '0;
            if (repeat_cfg >= 16'd1) begin
                passes = passes + 16'd1;
                if (passes >= repeat_cfg) begin
                    halt_player();
                    act = ACT_SILENCE;
                end
            end else begin
                halt_player();
                act = ACT_SILENCE;
            end
        end else if (note_due && freq_mem[slot(32'(note_pos))] != 16'd0) begin
            f        = freq_mem[slot(32'(note_pos))];
            d        = dur_mem[slot(32'(note_pos))];
            note_due = 1'b0;
            act      = ACT_TONE;
        end else if (dur_mem[slot(32'(note_pos))] != 16'd0 &&
                     note_ms >= {16'd0, dur_mem[slot(32'(note_pos))]}) begin
            note_ms  = note_ms - {16'd0, dur_mem[slot(32'(note_pos))]};
            note_pos = note_pos + 7'd1;
            note_due = 1'b1;
        end
        return act;
    endfunction

    function automatic player_result_t predict_result(input logic [2:0] mode,
                                                      input logic [IN_TDATA_W-1:0] data);
        player_result_t res;
        logic [15:0]    ms;
        logic [5:0]     idx;
        logic [15:0]    f;
        logic [15:0]    d;
        res = '0;
        f   = '0;
        d   = '0;
        ms  = data[15:0];
        idx = data[21:16];
        case (mode)
            CMD_TICK: begin
                if (run_state_q == PS_PLAYING) begin
                    res.action = advance_note(f, d);
                    if (run_state_q == PS_PLAYING) begin
                        if (32'(note_pos) < active_length() &&
                            dur_mem[slot(32'(note_pos))] != 16'd0)
                            note_ms = add_clamped(note_ms, ms);
                        if (limit_cfg != 16'd0)
                            total_ms = add_clamped(total_ms, ms);
                    end
                end
            end
            CMD_START: begin
                armed    = 1'b0;
                note_ms  = '0;
                passes   = '0;
                note_pos = '0;
                total_ms = '0;
                if (len_cfg == 7'd0) begin
                    run_state_q = PS_STOPPED;
                end else begin
                    run_state_q = PS_PLAYING;
                    armed       = 1'b1;
                    note_due    = 1'b1;
                end
            end
            CMD_RESUME: begin
                if (armed)
                    run_state_q = PS_PLAYING;
            end
            CMD_PAUSE: begin
                run_state_q = PS_PAUSED;
                res.action  = ACT_SILENCE;
            end
            CMD_STOP: begin
                halt_player();
                res.action = ACT_SILENCE;
            end
            CMD_WRITE: begin
                if (32'(idx) < TABLE_DEPTH) begin
                    freq_mem[slot(32'(idx))] = data[37:22];
                    dur_mem[slot(32'(idx))]  = data[53:38];
                end
            end
            default: ;
        endcase
        if (res.action == ACT_TONE) begin
            res.freq = f;
            res.dur  = d;
        end
        res.state = run_state_q;
        return res;
    endfunction

    function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_PATTERN_LENGTH: len_cfg    = value[6:0];
            CFG_REPEAT_COUNT:   repeat_cfg = value;
            CFG_MAX_DURATION:   limit_cfg  = value;
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk) begin
        player_result_t got;
        player_result_t want;
        if (!rst_n) begin
            reset_player();
        end else begin
            // Compare before taking a new input: a result never belongs to an item of this cycle.
            if (m_axis_tvalid && m_axis_tready) begin
                got.action = m_axis_tuser[1:0];
                got.freq   = m_axis_tdata[15:0];
                got.dur    = m_axis_tdata[31:16];
                got.state  = m_axis_tdata[33:32];
                if (due_results.size() == 0) begin
                    $error("result transfer with nothing outstanding: action %0d state %0d",
                           got.action, got.state);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("action", 32'(want.action), 32'(got.action));
                    check_field("tone_freq", 32'(want.freq), 32'(got.freq));
                    check_field("tone_duration", 32'(want.dur), 32'(got.dur));
                    check_field("player_state", 32'(want.state), 32'(got.state));
                    if (want.action == ACT_TONE)
                        tones_seen++;
                    else if (want.action == ACT_SILENCE)
                        silences_seen++;
                end
            end
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                due_results.push_back(predict_result(s_axis_tuser, s_axis_tdata));
        end
        results_due = due_results.size();
    end

endmodule

### tb/tb_tone_pattern_sequencer_unit.sv
module tb_tone_pattern_sequencer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tps_pkg::*;

    localparam int unsigned HOLD_OFF_CYCLES = 80;
    localparam int unsigned SOAK_TICKS      = 30;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]   s_axis_tuser  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [OUT_TUSER_W-1:0]  m_axis_tuser;
    logic                    cfg_valid     = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0]   cfg_data      = '0;

    int unsigned fail_count;
    int unsigned results_due;
    int unsigned tones_seen;
    int unsigned silences_seen;

    int unsigned send_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_seq       = 0;
    int unsigned hold_taken     = 0;
    int unsigned hold_left      = 0;
    int unsigned items_sent     = 0;
    int unsigned reg_writes     = 0;
    bit          written [DEFAULT_TABLE_DEPTH];

    tone_pattern_sequencer_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    tone_pattern_sequencer_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .results_due   (results_due),
        .tones_seen    (tones_seen),
        .silences_seen (silences_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output side: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_seq != hold_taken)
        begin
            hold_taken = hold_seq;
            hold_left  = HOLD_OFF_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial
    begin
        #20ms;
        $display("tb_tone_pattern_sequencer_unit NOT OK");
        $finish;
    end

    // Leave the item on the bus after its transfer; the next call replaces or idles it at the
    // following falling edge, and wait_drained drops valid.
    task automatic push_item(input logic [2:0] mode, input logic [15:0] ms,
                             input logic [5:0] idx, input logic [15:0] f, input logic [15:0] d);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {2'b00, d, f, idx, ms};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
    endtask

    task automatic put_entry(input logic [5:0] idx, input logic [15:0] f, input logic [15:0] d);
        push_item(CMD_WRITE, 16'($urandom), idx, f, d);
        written[idx] = 1'b1;
    endtask

    function automatic logic [15:0] pick_freq();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15)
            return '0;
        else if (r < 25)
            return 16'($urandom);
        return 16'($urandom_range(4000, 100));
    endfunction

    function automatic logic [15:0] pick_duration();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        else if (r < 13)
            return 16'hFFFF;
        else if (r < 20)
            return 16'($urandom);
        return 16'($urandom_range(60, 1));
    endfunction

    function automatic logic [15:0] pick_ms();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 65)
            return 16'($urandom_range(40));
        else if (r < 90)
            return 16'($urandom_range(400));
        else if (r < 95)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Wait for idle, load the registers, then fill any table entry the pattern can reach.
    task automatic set_player(input logic [15:0] len_word, input logic [15:0] repeats,
                              input logic [15:0] limit_ms);
        int unsigned reach;
        wait_drained();
        write_reg(CFG_PATTERN_LENGTH, len_word);
        write_reg(CFG_REPEAT_COUNT, repeats);
        write_reg(CFG_MAX_DURATION, limit_ms);
        reach = (32'(len_word[6:0]) > DEFAULT_TABLE_DEPTH) ? DEFAULT_TABLE_DEPTH
                                                           : 32'(len_word[6:0]);
        for (int i = 0; i < reach; i++)
            if (!written[6'(i)])
                put_entry(6'(i), pick_freq(), pick_duration());
    endtask

    // Mostly ticks with commands mixed in; unused modes do not count.
    task automatic random_item(output bit counted);
        int unsigned r;
        r = $urandom_range(99);
        counted = 1'b1;
        if (r < 58)
            push_item(CMD_TICK, pick_ms(), 6'($urandom), 16'($urandom), 16'($urandom));
        else if (r < 64)
            push_item(CMD_START, 16'($urandom), 6'($urandom), 16'($urandom), 16'($urandom));
        else if (r < 70)
            push_item(CMD_RESUME, 16'($urandom), 6'($urandom), 16'($urandom), 16'($urandom));
        else if (r < 75)
            push_item(CMD_PAUSE, 16'($urandom), 6'($urandom), 16'($urandom), 16'($urandom));
        else if (r < 79)
            push_item(CMD_STOP, 16'($urandom), 6'($urandom), 16'($urandom), 16'($urandom));
        else if (r < 94)
            put_entry(6'($urandom_range(DEFAULT_TABLE_DEPTH - 1)), pick_freq(), pick_duration());
        else
        begin
            push_item($urandom_range(1) ? CMD_NONE : MODE_UNUSED_HI,
                      16'($urandom), 6'($urandom), 16'($urandom), 16'($urandom));
            counted = 1'b0;
        end
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned done;
        bit          counted;
        done = 0;
        while (done < count)
        begin
            random_item(counted);
            if (counted)
                done++;
        end
    endtask

    task automatic set_idling(input int unsigned sender_pct, input int unsigned sink_pct);
        send_idle_pct  = sender_pct;
        sink_stall_pct = sink_pct;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty pattern: start is refused and resume stays refused.
        push_item(CMD_START, 16'd0, 6'd0, 16'd0, 16'd0);
        push_item(CMD_RESUME, 16'd0, 6'd0, 16'd0, 16'd0);
        push_item(MODE_UNUSED_HI, 16'hFFFF, 6'h3F, 16'hFFFF, 16'hFFFF);
        push_item(CMD_PAUSE, 16'd0, 6'd0, 16'd0, 16'd0);
        push_item(CMD_STOP, 16'd0, 6'd0, 16'd0, 16'd0);

        put_entry(6'd0, 16'd440, 16'd10);
        put_entry(6'd1, 16'd0, 16'd5);
        put_entry(6'd2, 16'hFFFF, 16'd1);
        put_entry(6'd63, 16'd1, 16'hFFFF);
        wait_drained();
        write_reg(CFG_UNUSED, 16'hFFFF);
        set_player(16'd3, 16'd2, 16'd0);

        // Walk the short pattern: tone, silent note, last note, pause, wrap, stop and resume.
        push_item(CMD_START, 16'd0, 6'd0, 16'd0, 16'd0);
        push_item(CMD_TICK, 16'd0, 6'd0, 16'd0, 16'd0);
        push_item(CMD_TICK, 16'd10, 6'd0, 16'd0, 16'd0);
        push_item(CMD_TICK, 16'd0, 6'd0, 16'd0, 16'd0);
        push_item(CMD_TICK, 16'd5, 6'd0, 16'd0, 16'd0);
        push_item(CMD_TICK, 16'd0, 6'd0, 16'd0, 16'd0);
        push_item(CMD_TICK, 16'd0, 6'd0, 16'd0, 16'd0);
        push_item(CMD_PAUSE, 16'd0, 6'd0, 16'd0, 16'd0);
        push_item(CMD_TICK, 16'd7, 6'd0, 16'd0, 16'd0);
        push_item(CMD_RESUME, 16'd0, 6'd0, 16'd0, 16'd0);
        push_item(CMD_TICK, 16'd1, 6'd0, 16'd0, 16'd0);
        push_item(CMD_TICK, 16'd0, 6'd0, 16'd0, 16'd0);
        push_item(CMD_TICK, 16'd0, 6'd0, 16'd0, 16'd0);
        push_item(CMD_STOP, 16'd0, 6'd0, 16'd0, 16'd0);
        push_item(CMD_RESUME, 16'd0, 6'd0, 16'd0, 16'd0);
        push_item(CMD_TICK, 16'd0, 6'd0, 16'd0, 16'd0);
        push_item(CMD_START, 16'd0, 6'd0, 16'd0, 16'd0);
        push_item(CMD_TICK, 16'hFFFF, 6'd0, 16'd0, 16'd0);
        run_random(140);

        set_idling(79, 0);
        set_player(16'hFFC0, 16'd0, 16'hFFFF);
        run_random(140);

        // Length beyond the table, many passes, a 1 ms limit.
        set_idling(0, 79);
        set_player(16'h007F, 16'hFFFF, 16'd1);
        run_random(140);

        set_idling(24, 24);
        set_player(16'd1, 16'd1, 16'd300);
        run_random(140);

        // Hold the output off while items keep coming, then pause until everything is back.
        set_idling(0, 0);
        set_player(16'($urandom_range(12, 2)), 16'($urandom_range(5, 2)),
                   $urandom_range(1) ? 16'd0 : 16'($urandom_range(2000, 50)));
        push_item(CMD_START, 16'($urandom), 6'($urandom), 16'($urandom), 16'($urandom));
        hold_seq++;
        repeat (12)
            push_item(CMD_TICK, pick_ms(), 6'($urandom), 16'($urandom), 16'($urandom));
        wait_drained();
        run_random(140);

        // Full-size ticks on a one-note pattern that wraps on every pass.
        set_player(16'd1, 16'hFFFF, 16'd0);
        put_entry(6'd0, 16'd1000, 16'd1);
        push_item(CMD_START, 16'd0, 6'd0, 16'd0, 16'd0);
        repeat (SOAK_TICKS)
            push_item(CMD_TICK, 16'hFFFF, 6'd0, 16'd0, 16'd0);

        wait_drained();
        repeat (20) @(posedge clk);

        $display("Run covered %0d input transfers (%0d full-size ticks on a one-note loop),",
                 items_sent, SOAK_TICKS);
        $display("%0d register writes, six player setups, four idling profiles; %0d tones, %0d silences",
                 reg_writes, tones_seen, silences_seen);
        if (fail_count == 0)
            $display("tb_tone_pattern_sequencer_unit OK");
        else
            $display("tb_tone_pattern_sequencer_unit NOT OK");
        $finish;
    end

endmodule
